// ----- sv/cubic_hermite_interp_macros.svh -----
// Assertion helpers for the cubic Hermite interpolator.
`ifndef CUBIC_HERMITE_INTERP_MACROS_SVH
`define CUBIC_HERMITE_INTERP_MACROS_SVH

// same-cycle implication
`define CHI_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CHI_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/chi_pkg.sv -----
`default_nettype none
package chi_pkg;
	localparam int MAX_KNOTS_DEF = 64;
	localparam int MIN_KNOTS = 2;
	localparam int VW = 32;
	localparam int KCW = 7;
	localparam int IDXW = 6;
	localparam int STW = 3;
	localparam int SEGW = 7;
	localparam int MW = 34;
	localparam int PW = 68;
	localparam int QBITS = 32;
	localparam int Q31 = 31;
	localparam int FRAC_BITS = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		STAT_OK      = 3'd0,
		STAT_WRITTEN = 3'd1,
		STAT_BELOW   = 3'd2,
		STAT_ABOVE   = 3'd3,
		STAT_SAT     = 3'd4
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SRCH_ADDR,
		S_SRCH_CMP,
		S_FETCH,
		S_EDGE,
		S_LOAD_L,
		S_LOAD_R,
		S_PREP,
		S_DIV,
		S_MS2,
		S_MS3,
		S_MB,
		S_MP1,
		S_MP2,
		S_MT,
		S_MP4,
		S_MY,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                 en;
		logic signed [MW-1:0] a;
		logic signed [MW-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic signed [VW-1:0] x;
		logic signed [VW-1:0] y;
		logic signed [VW-1:0] d;
	} knot_t;
endpackage
`default_nettype wire

// ----- sv/chi_ram.sv -----
`default_nettype none
module chi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- sv/chi_mul.sv -----
`default_nettype none
module chi_mul import chi_pkg::*; (
	input  wire logic                 clk,
	input  wire mul_req_t             req,
	output logic signed [PW-1:0]      prod
);
	logic signed [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= req.a * req.b;
		end
	end

	assign prod = prod_q;
endmodule
`default_nettype wire

// ----- sv/cubic_hermite_interp.sv -----
// Cubic Hermite interpolator over a 64-entry knot table (MAX_KNOTS).
// Input channel (in_valid/in_ready): op selects a knot write (knot_index,
// knot_x, knot_y, knot_slope) or a query (query_x). Every word gives one
// result word on the output channel (out_valid/out_ready): value, status,
// segment. cfg_we/cfg_wdata set knot_count; the user must write it only
// while idle, as the block itself does not enforce this. A knot write
// goes from idle straight to S_DONE. A query runs a binary search (up to
// 7 probes for 64 knots), fetches the segment ends, does a restoring
// division over 32 quotient bits for the segment fraction, then 8 steps
// that use one shared 34x34 multiplier for six products. Queries at
// the range edges skip the division and the multiplier steps.
// The block takes one word at a time: in_ready is high only when idle.
// The result sits in an output register; a new word is accepted while it
// waits, and the next result is held until the receiver takes the first.
// Reset clears control and sets knot_count to 2; knot contents stay
// undefined until written.
`default_nettype none
`include "cubic_hermite_interp_macros.svh"
module cubic_hermite_interp import chi_pkg::*; #(
	parameter int MAX_KNOTS = MAX_KNOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 op,
	input  wire logic [IDXW-1:0]      knot_index,
	input  wire logic signed [VW-1:0] knot_x,
	input  wire logic signed [VW-1:0] knot_y,
	input  wire logic signed [VW-1:0] knot_slope,
	input  wire logic signed [VW-1:0] query_x,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic signed [VW-1:0]      value,
	output logic [STW-1:0]            status,
	output logic [SEGW-1:0]           segment,
	input  wire logic                 cfg_we,
	input  wire logic [KCW-1:0]       cfg_wdata
);
	localparam int AW = $clog2(MAX_KNOTS);
	localparam int NW = $clog2(MAX_KNOTS + 1);
	localparam int KW = (KCW > NW) ? KCW : NW;
	localparam int IW = (IDXW > NW) ? IDXW : NW;
	localparam int DCW = $clog2(QBITS);
	localparam int KB = $bits(knot_t);
	localparam logic signed [VW+3:0] ONE_W = (VW+4)'(1) <<< Q31;

	state_t state_q, state_d;
	logic [KCW-1:0] kc_q;
	logic [KW-1:0] kc_ext;
	logic [NW-1:0] n_c, n_q, first_q, count_q, probe_q, step_c;
	logic in_acc, out_load, we_c, qbit_c;
	logic [AW-1:0] raddr_c, waddr_c;
	logic [KB-1:0] rdata_w;
	knot_t rd_knot, wr_knot;
	logic signed [VW-1:0] x_q, xl_q, yl_q, dl_q, dr_q;
	logic signed [VW:0] h_q, u_q, dd_q, uc_c;
	logic [VW+1:0] rem_q, r_c;
	logic signed [VW+2:0] diff_c;
	logic [QBITS-1:0] quo_q;
	logic [DCW-1:0] dcnt_q;
	logic [VW-1:0] s2_q, s2_c, s3_c;
	logic signed [VW+3:0] s_x, s2_x, s3_x, b01_w, b10_w, b11_w;
	logic signed [VW:0] b01_q, b10_q, b11_q;
	logic signed [PW-1:0] prod, acc_q, tsum_c, ysum_c;
	logic signed [MW-1:0] t_q;
	mul_req_t mreq;
	logic signed [VW-1:0] res_val_q, value_q;
	status_t res_st_q, status_q;
	logic [SEGW-1:0] res_seg_q, segment_q;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		kc_ext = KW'(kc_q);
		if (kc_ext < KW'(MIN_KNOTS)) begin
			n_c = NW'(MIN_KNOTS);
		end else if (kc_ext > KW'(MAX_KNOTS)) begin
			n_c = NW'(MAX_KNOTS);
		end else begin
			n_c = NW'(kc_ext);
		end
	end

	assign step_c = count_q >> 1;
	assign wr_knot = '{x: knot_x, y: knot_y, d: knot_slope};
	assign we_c = in_acc && (op == OP_WRITE) && (IW'(knot_index) < IW'(MAX_KNOTS));
	assign waddr_c = AW'(knot_index);
	assign rd_knot = knot_t'(rdata_w);

	chi_ram #(.WIDTH(KB), .DEPTH(MAX_KNOTS)) u_ram (
		.clk  (clk),
		.we   (we_c),
		.waddr(waddr_c),
		.wdata(wr_knot),
		.raddr(raddr_c),
		.rdata(rdata_w)
	);

	chi_mul u_mul (
		.clk (clk),
		.req (mreq),
		.prod(prod)
	);

	// divider step
	assign diff_c = $signed({1'b0, rem_q}) - (VW+3)'(h_q);
	assign qbit_c = !diff_c[VW+2];
	assign r_c = qbit_c ? diff_c[VW+1:0] : rem_q;

	assign uc_c = u_q[VW] ? '0 : ((u_q > h_q) ? h_q : u_q);
	assign s2_c = prod[2*VW-2:VW-1];
	assign s3_c = prod[2*VW-2:VW-1];
	assign s_x = (VW+4)'(quo_q);
	assign s2_x = (VW+4)'(s2_q);
	assign s3_x = (VW+4)'(s3_c);
	assign b01_w = s2_x + (s2_x <<< 1) - (s3_x <<< 1);
	assign b10_w = s3_x - (s2_x <<< 1) + s_x;
	assign b11_w = s3_x - s2_x;
	assign tsum_c = acc_q + prod;
	assign ysum_c = PW'(yl_q) + acc_q + (prod >>> FRAC_BITS);

	always_comb begin
		state_d = state_q;
		raddr_c = '0;
		mreq = '{en: 1'b0, a: '0, b: '0};
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					state_d = (op == OP_QUERY) ? S_SRCH_ADDR : S_DONE;
				end
			end
			S_SRCH_ADDR: begin
				if (count_q == '0) begin
					state_d = S_FETCH;
				end else begin
					raddr_c = AW'(first_q + step_c);
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: state_d = S_SRCH_ADDR;
			S_FETCH: begin
				if (first_q == '0) begin
					raddr_c = '0;
					state_d = S_EDGE;
				end else if (first_q >= n_q) begin
					raddr_c = AW'(n_q - NW'(1));
					state_d = S_EDGE;
				end else begin
					raddr_c = AW'(first_q - NW'(1));
					state_d = S_LOAD_L;
				end
			end
			S_EDGE: state_d = S_DONE;
			S_LOAD_L: begin
				raddr_c = AW'(first_q);
				state_d = S_LOAD_R;
			end
			S_LOAD_R: state_d = S_PREP;
			S_PREP: state_d = (!h_q[VW] && h_q != '0) ? S_DIV : S_DONE;
			S_DIV: begin
				if (dcnt_q == '1) begin
					state_d = S_MS2;
				end
			end
			S_MS2: begin
				mreq = '{en: 1'b1, a: MW'(quo_q), b: MW'(quo_q)};
				state_d = S_MS3;
			end
			S_MS3: begin
				mreq = '{en: 1'b1, a: MW'(s2_c), b: MW'(quo_q)};
				state_d = S_MB;
			end
			S_MB: state_d = S_MP1;
			S_MP1: begin
				mreq = '{en: 1'b1, a: MW'(dl_q), b: MW'(b10_q)};
				state_d = S_MP2;
			end
			S_MP2: begin
				mreq = '{en: 1'b1, a: MW'(dr_q), b: MW'(b11_q)};
				state_d = S_MT;
			end
			S_MT: begin
				mreq = '{en: 1'b1, a: MW'(dd_q), b: MW'(b01_q)};
				state_d = S_MP4;
			end
			S_MP4: begin
				mreq = '{en: 1'b1, a: MW'(h_q), b: t_q};
				state_d = S_MY;
			end
			S_MY: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kc_q <= KCW'(MIN_KNOTS);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				kc_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= res_val_q;
			status_q <= res_st_q;
			segment_q <= res_seg_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					x_q <= query_x;
					n_q <= n_c;
					first_q <= '0;
					count_q <= n_c;
					res_val_q <= '0;
					res_st_q <= STAT_WRITTEN;
					res_seg_q <= '0;
				end
			end
			S_SRCH_ADDR: probe_q <= first_q + step_c;
			S_SRCH_CMP: begin
				if (rd_knot.x < x_q) begin
					first_q <= probe_q + NW'(1);
					count_q <= count_q - step_c - NW'(1);
				end else begin
					count_q <= step_c;
				end
			end
			S_EDGE: begin
				res_val_q <= rd_knot.y;
				if (first_q == '0) begin
					res_st_q <= (x_q < rd_knot.x) ? STAT_BELOW : STAT_OK;
					res_seg_q <= '0;
				end else begin
					res_st_q <= STAT_ABOVE;
					res_seg_q <= SEGW'(n_q);
				end
			end
			S_LOAD_L: begin
				xl_q <= rd_knot.x;
				yl_q <= rd_knot.y;
				dl_q <= rd_knot.d;
			end
			S_LOAD_R: begin
				h_q <= (VW+1)'(rd_knot.x) - (VW+1)'(xl_q);
				u_q <= (VW+1)'(x_q) - (VW+1)'(xl_q);
				dd_q <= (VW+1)'(rd_knot.y) - (VW+1)'(yl_q);
				dr_q <= rd_knot.d;
			end
			S_PREP: begin
				res_val_q <= yl_q;
				res_st_q <= STAT_OK;
				res_seg_q <= SEGW'(first_q);
				rem_q <= (VW+2)'($unsigned(uc_c));
				dcnt_q <= '0;
			end
			S_DIV: begin
				rem_q <= {r_c[VW:0], 1'b0};
				quo_q <= {quo_q[QBITS-2:0], qbit_c};
				dcnt_q <= dcnt_q + DCW'(1);
			end
			S_MS3: s2_q <= s2_c;
			S_MB: begin
				if (b01_w[VW+3]) begin
					b01_q <= '0;
				end else if (b01_w > ONE_W) begin
					b01_q <= ONE_W[VW:0];
				end else begin
					b01_q <= b01_w[VW:0];
				end
				b10_q <= b10_w[VW:0];
				b11_q <= b11_w[VW:0];
			end
			S_MP2: acc_q <= prod;
			S_MT: t_q <= MW'(tsum_c >>> Q31);
			S_MP4: acc_q <= prod >>> Q31;
			S_MY: begin
				if (ysum_c[PW-1:VW-1] == '0 || ysum_c[PW-1:VW-1] == '1) begin
					res_val_q <= ysum_c[VW-1:0];
				end else begin
					res_st_q <= STAT_SAT;
					res_val_q <= ysum_c[PW-1] ? {1'b1, {(VW-1){1'b0}}}
						: {1'b0, {(VW-1){1'b1}}};
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign status = status_q;
	assign segment = segment_q;

	`CHI_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted word left block idle")
	`CHI_IMP(a_write_result, out_valid && status == STAT_WRITTEN, value == '0 && segment == '0, "write result not zero")
	`CHI_IMP(a_search_bounds, state_q == S_SRCH_ADDR, (NW+1)'(first_q) + (NW+1)'(count_q) <= (NW+1)'(n_q), "search window past knot count")
	`CHI_IMP(a_div_divisor, state_q == S_DIV, !h_q[VW] && h_q != '0, "division by non-positive width")
endmodule
`default_nettype wire
